/* design/dp3_pkg.sv */
package dp3_pkg;

    // Sequencer states of the decoder.
    typedef enum logic [3:0] {
        ST_FLAG,
        ST_START,
        ST_COUNT,
        ST_MASK,
        ST_CODES,
        ST_ESC,
        ST_RAW,
        ST_WALK,
        ST_FETCH,
        ST_EMIT
    } dp3_state_t;

    // Fixed storage and field sizes.
    localparam int MASK_DEPTH = 32;
    localparam int POS_W      = 9;
    localparam int BUF_W      = 11;
    localparam int FILL_W     = 4;
    localparam int CHAN_MAX   = 3;

    // One byte write into the block store.
    typedef struct packed {
        logic       en;
        logic [8:0] sample;
        logic [1:0] chan;
        logic [7:0] data;
    } dp3_wr_t;

endpackage

/* design/dp3_delta_alu.sv */
module dp3_delta_alu
    import dp3_pkg::*;
(
    input  logic [7:0] running,
    input  logic [2:0] code,
    input  logic [7:0] esc_byte,
    input  logic       use_esc,
    output logic [7:0] sum
);

    logic [7:0] delta;

    // A 3-bit code is a signed delta; an escape adds a full byte.
    always_comb
    begin
        delta = use_esc ? esc_byte : {{5{code[2]}}, code};
        sum   = running + delta;
    end

endmodule

/* design/dp3_block_store.sv */
module dp3_block_store
    import dp3_pkg::*;
#(
    parameter int WORDS = 64,
    parameter int AW    = 6
)
(
    input  logic                         clk,
    input  dp3_wr_t                      wr,
    input  logic [AW-1:0]                rd_addr,
    output logic [CHAN_MAX-1:0][31:0]    rd_data
);

    // One word of four samples per channel; writes go a byte at a time.
    for (genvar c = 0; c < CHAN_MAX; c++)
    begin : g_chan
        logic [31:0] mem [WORDS];

        always_ff @(posedge clk)
        begin
            if (wr.en && wr.chan == 2'(c))
            begin
                mem[wr.sample[AW+1:2]][{wr.sample[1:0], 3'b000} +: 8] <= wr.data;
            end
            rd_data[c] <= mem[rd_addr];
        end
    end

endmodule

/* design/delta3_plane_block_decoder.sv */
// Delta-coded plane block decoder.
// Input: one byte of the packed stream is taken at each rising edge where
// start is high and busy is low. A block is a flag byte followed by the
// channel planes, each either raw samples or a packed plane (start byte,
// code count, zero mask, code bytes, escape bytes as the walk needs them).
// Output: when the last plane of a block is complete, the block leaves as
// (PLANE_SAMPLES+3)/4 items of four pixels, one per cycle, each shown for
// one cycle with result_strobe high. block_last marks the final item and
// format_error tells whether any plane read past its declared code bytes.
// Walk: after the last mask or code byte and after each escape byte, the
// walk unit advances one sample per cycle, except while it fetches a code
// byte from the code memory (a walk step and a fetch state), takes an extra
// step for each read past the declared code bytes, decodes an escape code
// and waits for its byte, or closes the plane.
// Each emitted item comes from a registered read of the block store. busy is
// high during the walk and emission, but low while the walk waits for an
// escape byte.
// Reset puts the block back to waiting for a flag byte. Results cannot be
// held off by the receiver; they must be taken in the cycle shown.
module delta3_plane_block_decoder
    import dp3_pkg::*;
#(
    parameter int PLANE_SAMPLES = 256,
    parameter int PLANE_COUNT   = 3,
    parameter int MASK_BYTES    = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  in_byte,
    output logic        result_strobe,
    output logic [23:0] pixel_a,
    output logic [23:0] pixel_b,
    output logic [23:0] pixel_c,
    output logic [23:0] pixel_d,
    output logic        block_last,
    output logic        format_error
);

    localparam int WORDS = (PLANE_SAMPLES + 3) / 4;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

    dp3_state_t state_reg, state_next;

    logic [2:0]        flags_reg, flags_next;
    logic [1:0]        plane_reg, plane_next;
    logic [8:0]        bcnt_reg, bcnt_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [7:0]        run_reg, run_next;
    logic [7:0]        ccount_reg, ccount_next;
    logic [7:0]        ptr_reg, ptr_next;
    logic [BUF_W-1:0]  buf_reg, buf_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              err_reg, err_next;
    logic [AW-1:0]     ecnt_reg, ecnt_next;
    logic [AW-1:0]     oword_reg;
    logic              strobe_reg;

    logic [7:0]        mask_mem [MASK_DEPTH];
    logic [7:0]        code_mem [256];
    logic [7:0]        code_rd_reg;

    logic              accept;
    logic              pos_done;
    logic              mbit;
    logic [2:0]        ck;
    logic              use_esc;
    logic [7:0]        alu_sum;
    logic              last_plane;
    logic              next_packed;
    logic [1:0]        plane_inc;
    dp3_wr_t           wr;
    logic [CHAN_MAX-1:0][31:0] rd_data;

    assign accept = start && !busy;

    // Walk decode: mask bit and next code for the current sample, plane end and next plane.
    always_comb
    begin
        pos_done    = (pos_reg >= POS_W'(PLANE_SAMPLES));
        mbit        = ({1'b0, pos_reg[7:3]} < 6'(MASK_BYTES))
                      ? mask_mem[pos_reg[7:3]][pos_reg[2:0]] : 1'b0;
        ck          = buf_reg[2:0];
        use_esc     = (state_reg == ST_ESC);
        plane_inc   = plane_reg + 2'd1;
        last_plane  = (3'(plane_inc) >= 3'(PLANE_COUNT));
        next_packed = flags_reg[plane_inc];
    end

    dp3_delta_alu u_alu
    (
        .running  (run_reg),
        .code     (ck),
        .esc_byte (in_byte),
        .use_esc  (use_esc),
        .sum      (alu_sum)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_FLAG:
                if (accept) state_next = flags_next[0] ? ST_START : ST_RAW;
            ST_START:
                if (accept) state_next = ST_COUNT;
            ST_COUNT:
                if (accept) state_next = ST_MASK;
            ST_MASK:
                if (accept && bcnt_reg + 9'd1 >= 9'(MASK_BYTES))
                    state_next = (ccount_reg == 8'd0) ? ST_WALK : ST_CODES;
            ST_CODES:
                if (accept && bcnt_reg + 9'd1 >= {1'b0, ccount_reg})
                    state_next = ST_WALK;
            ST_ESC:
                if (accept) state_next = ST_WALK;
            ST_RAW:
                if (accept && bcnt_reg + 9'd1 >= 9'(PLANE_SAMPLES))
                begin
                    priority if (last_plane) state_next = ST_EMIT;
                    else state_next = next_packed ? ST_START : ST_RAW;
                end
            ST_WALK:
            begin
                priority if (pos_done)
                begin
                    priority if (last_plane) state_next = ST_EMIT;
                    else state_next = next_packed ? ST_START : ST_RAW;
                end
                else if (mbit && fill_reg < 4'd3 && ptr_reg < ccount_reg)
                    state_next = ST_FETCH;
                else if (mbit && fill_reg >= 4'd3 && ck == 3'd0)
                    state_next = ST_ESC;
            end
            ST_FETCH:
                state_next = ST_WALK;
            ST_EMIT:
                if (ecnt_reg == AW'(WORDS - 1)) state_next = ST_FLAG;
            default:
                state_next = ST_FLAG;
        endcase
    end

    // Datapath next values and block store write.
    always_comb
    begin
        flags_next  = flags_reg;
        plane_next  = plane_reg;
        bcnt_next   = bcnt_reg;
        pos_next    = pos_reg;
        run_next    = run_reg;
        ccount_next = ccount_reg;
        ptr_next    = ptr_reg;
        buf_next    = buf_reg;
        fill_next   = fill_reg;
        err_next    = err_reg;
        ecnt_next   = ecnt_reg;
        wr          = '0;
        wr.chan     = plane_reg;
        unique case (state_reg)
            ST_FLAG:
                if (accept)
                begin
                    flags_next = in_byte[2:0];
                    plane_next = 2'd0;
                    err_next   = 1'b0;
                    bcnt_next  = 9'd0;
                end
            ST_START:
                if (accept)
                begin
                    run_next  = in_byte;
                    pos_next  = POS_W'(1);
                    wr.en     = 1'b1;
                    wr.sample = 9'd0;
                    wr.data   = in_byte;
                end
            ST_COUNT:
                if (accept)
                begin
                    ccount_next = in_byte;
                    ptr_next    = 8'd0;
                    buf_next    = '0;
                    fill_next   = '0;
                    bcnt_next   = 9'd0;
                end
            ST_MASK, ST_CODES:
                if (accept)
                begin
                    bcnt_next = bcnt_reg + 9'd1;
                    if (state_next != state_reg)
                        bcnt_next = 9'd0;
                end
            ST_ESC:
                if (accept)
                begin
                    run_next  = alu_sum;
                    wr.en     = 1'b1;
                    wr.sample = pos_reg;
                    wr.data   = alu_sum;
                    pos_next  = pos_reg + POS_W'(1);
                end
            ST_RAW:
                if (accept)
                begin
                    wr.en     = 1'b1;
                    wr.sample = bcnt_reg;
                    wr.data   = in_byte;
                    bcnt_next = bcnt_reg + 9'd1;
                    if (bcnt_reg + 9'd1 >= 9'(PLANE_SAMPLES))
                    begin
                        plane_next = plane_inc;
                        bcnt_next  = 9'd0;
                    end
                end
            ST_WALK:
            begin
                priority if (pos_done)
                begin
                    plane_next = plane_inc;
                    bcnt_next  = 9'd0;
                end
                else if (!mbit)
                begin
                    wr.en     = 1'b1;
                    wr.sample = pos_reg;
                    wr.data   = run_reg;
                    pos_next  = pos_reg + POS_W'(1);
                end
                else if (fill_reg < 4'd3)
                begin
                    // Read past the declared codes: zero bits and an error.
                    if (ptr_reg >= ccount_reg)
                    begin
                        fill_next = fill_reg + 4'd8;
                        err_next  = 1'b1;
                        if (ptr_reg != 8'hff) ptr_next = ptr_reg + 8'd1;
                    end
                end
                else
                begin
                    buf_next  = buf_reg >> 3;
                    fill_next = fill_reg - 4'd3;
                    if (ck != 3'd0)
                    begin
                        run_next  = alu_sum;
                        wr.en     = 1'b1;
                        wr.sample = pos_reg;
                        wr.data   = alu_sum;
                        pos_next  = pos_reg + POS_W'(1);
                    end
                end
            end
            ST_FETCH:
            begin
                buf_next  = buf_reg | BUF_W'({3'b000, code_rd_reg} << fill_reg);
                fill_next = fill_reg + 4'd8;
                if (ptr_reg != 8'hff) ptr_next = ptr_reg + 8'd1;
            end
            ST_EMIT:
                ecnt_next = (ecnt_reg == AW'(WORDS - 1)) ? '0 : ecnt_reg + AW'(1);
            default:
                ;
        endcase
    end

    // Control and walk registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_FLAG;
            flags_reg  <= '0;
            plane_reg  <= '0;
            bcnt_reg   <= '0;
            pos_reg    <= '0;
            run_reg    <= '0;
            ccount_reg <= '0;
            ptr_reg    <= '0;
            buf_reg    <= '0;
            fill_reg   <= '0;
            err_reg    <= 1'b0;
            ecnt_reg   <= '0;
            strobe_reg <= 1'b0;
            oword_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            flags_reg  <= flags_next;
            plane_reg  <= plane_next;
            bcnt_reg   <= bcnt_next;
            pos_reg    <= pos_next;
            run_reg    <= run_next;
            ccount_reg <= ccount_next;
            ptr_reg    <= ptr_next;
            buf_reg    <= buf_next;
            fill_reg   <= fill_next;
            err_reg    <= err_next;
            ecnt_reg   <= ecnt_next;
            strobe_reg <= (state_reg == ST_EMIT);
            oword_reg  <= ecnt_reg;
        end
    end

    // Mask bytes and code bytes of the current plane.
    always_ff @(posedge clk)
    begin
        if (accept && state_reg == ST_MASK)
            mask_mem[bcnt_reg[4:0]] <= in_byte;
        if (accept && state_reg == ST_CODES)
            code_mem[bcnt_reg[7:0]] <= in_byte;
        code_rd_reg <= code_mem[ptr_reg];
    end

    dp3_block_store #(
        .WORDS (WORDS),
        .AW    (AW)
    ) u_store
    (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (ecnt_reg),
        .rd_data (rd_data)
    );

    // Pixel assembly: missing channels and padding pixels read as zero.
    logic [3:0][23:0] pix;
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            pix[j] = '0;
            for (int c = 0; c < CHAN_MAX; c++)
            begin
                if (c < PLANE_COUNT && 9'({oword_reg, 2'(j)}) < 9'(PLANE_SAMPLES))
                    pix[j][8*c +: 8] = rd_data[c][8*j +: 8];
            end
        end
    end

    assign busy          = (state_reg == ST_WALK) || (state_reg == ST_FETCH)
                           || (state_reg == ST_EMIT);
    assign result_strobe = strobe_reg;
    assign pixel_a       = pix[0];
    assign pixel_b       = pix[1];
    assign pixel_c       = pix[2];
    assign pixel_d       = pix[3];
    assign block_last    = (oword_reg == AW'(WORDS - 1));
    assign format_error  = err_reg;

    // A code fetch always follows a walk step.
    a_fetch_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FETCH |-> $past(state_reg) == ST_WALK)
        else $error("code fetch without walk step");

    // The bit buffer never holds more bits than it can.
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 4'd10)
        else $error("bit buffer overfilled");

    // Results only come out of an emission pass.
    a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(state_reg) == ST_EMIT)
        else $error("result outside emission");

    // The block stays busy until its final item is out.
    a_busy_mid: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !block_last |-> busy)
        else $error("input taken during emission");

endmodule
